// File: hw/rtl/dst_pkg.sv
// ----------------------------------------------------------------------------
// dst_pkg
// shared widths, codes and controller/datapath interface types for the
// square-wave tone generator with pitch glide
// ----------------------------------------------------------------------------
package dst_pkg;

  localparam int unsigned OP_W      = 2;
  localparam int unsigned MS_W      = 16;
  localparam int unsigned CNT_W     = 10;
  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned INC_W     = 32;
  localparam int unsigned AMP_W     = 15;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_W     = 32;

  // samples held back in one block, upper bound for a rewind
  localparam int unsigned BLOCK_SAMPLES = 512;

  localparam logic [AMP_W-1:0] AMP_RESET = AMP_W'(16000);

  // glide product: span magnitude times elapsed milliseconds
  localparam int unsigned PROD_W    = INC_W + MS_W;
  // restoring divider, one quotient bit a cycle
  localparam int unsigned DIV_STEPS = PROD_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  typedef enum logic [OP_W-1:0] {
    OP_SAMPLE  = 2'd0,
    OP_REWIND  = 2'd1,
    OP_RESTART = 2'd2,
    OP_NOP     = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_INC = 3'd0,
    CFG_END_INC   = 3'd1,
    CFG_DURATION  = 3'd2,
    CFG_GLIDE_EN  = 3'd3,
    CFG_AMPLITUDE = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic capture;     // latch the request and derived operands
    logic mul;         // load the product register
    logic div_step;    // one divider iteration
    logic inc_update;  // store the new increment
    logic commit;      // update phase, write the output register
  } dst_cmd_t;

  typedef struct packed {
    op_e  op;
    logic need_div;
  } dst_status_t;

endpackage

// File: hw/rtl/dst_ctrl.sv
// ----------------------------------------------------------------------------
// dst_ctrl
// sequencer for one request at a time, owns the output valid flag
// ----------------------------------------------------------------------------
module dst_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  dst_pkg::dst_status_t status_i,
  output dst_pkg::dst_cmd_t  cmd_o
);
  import dst_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_DIV,
    S_INC,
    S_FIN
  } state_e;

  state_e               state_q;
  logic                 out_valid_q;
  logic [DIV_CNT_W-1:0] div_cnt_q;
  logic                 slot_free;
  logic                 div_last;

  assign slot_free = !out_valid_q || out_ready_i;
  assign div_last  = (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1));

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o            = '0;
    cmd_o.capture    = (state_q == S_IDLE) && in_valid_i;
    cmd_o.mul        = (state_q == S_EVAL);
    cmd_o.div_step   = (state_q == S_DIV);
    cmd_o.inc_update = (state_q == S_INC);
    cmd_o.commit     = (state_q == S_FIN) && slot_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      div_cnt_q   <= '0;
    end else begin
      if (cmd_o.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_EVAL;
          end
        end
        S_EVAL: begin
          div_cnt_q <= '0;
          if (status_i.op == OP_SAMPLE) begin
            state_q <= status_i.need_div ? S_DIV : S_INC;
          end else begin
            state_q <= S_FIN;
          end
        end
        S_DIV: begin
          div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
          if (div_last) begin
            state_q <= S_INC;
          end
        end
        S_INC: begin
          state_q <= S_FIN;
        end
        S_FIN: begin
          if (slot_free) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: hw/rtl/dst_dp.sv
// ----------------------------------------------------------------------------
// dst_dp
// configuration registers, phase and increment state, multiplier, serial
// divider and output payload register
// ----------------------------------------------------------------------------
module dst_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [dst_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [dst_pkg::CFG_W-1:0]       cfg_data_i,
  input  logic [dst_pkg::OP_W-1:0]        opcode_i,
  input  logic [dst_pkg::MS_W-1:0]        elapsed_ms_i,
  input  logic [dst_pkg::CNT_W-1:0]       rewind_count_i,
  input  dst_pkg::dst_cmd_t               cmd_i,
  output dst_pkg::dst_status_t            status_o,
  output logic signed [dst_pkg::SAMPLE_W-1:0] sample_o,
  output logic                            sample_valid_o
);
  import dst_pkg::*;

  // configuration
  logic [INC_W-1:0] start_inc_q;
  logic [INC_W-1:0] end_inc_q;
  logic [MS_W-1:0]  dur_q;
  logic             glide_q;
  logic [AMP_W-1:0] amp_q;

  // state
  logic [INC_W-1:0] phase_q;
  logic [INC_W-1:0] cur_inc_q;

  // request operands
  op_e              op_q;
  logic [MS_W-1:0]  elapsed_q;
  logic [CNT_W-1:0] count_sat_q;
  logic             need_div_q;
  logic [INC_W-1:0] span_mag_q;
  logic             span_neg_q;

  // product / dividend-quotient shift register and remainder
  logic [PROD_W-1:0] prod_q;
  logic [MS_W-1:0]   rem_q;

  logic [SAMPLE_W-1:0]  sample_q;
  logic                 sample_valid_q;

  logic [CNT_W-1:0]       count_sat;
  logic                   span_neg;
  logic [PROD_W-1:0]      glide_full;
  logic [INC_W+CNT_W-1:0] rew_full;
  logic [MS_W:0]          rem_shift;
  logic                   rem_ge;
  logic [INC_W-1:0]       quot;
  logic [INC_W-1:0]       part;
  logic [INC_W-1:0]       inc_new;
  logic [INC_W-1:0]       phase_adv;
  logic [SAMPLE_W-1:0]    amp_ext;
  logic [SAMPLE_W-1:0]    level;

  assign count_sat = (32'(rewind_count_i) > 32'(BLOCK_SAMPLES)) ?
                     CNT_W'(BLOCK_SAMPLES) : rewind_count_i;
  assign span_neg  = (end_inc_q < start_inc_q);

  assign glide_full = span_mag_q * elapsed_q;
  assign rew_full   = count_sat_q * cur_inc_q;

  // restoring division step
  assign rem_shift = {rem_q, prod_q[PROD_W-1]};
  assign rem_ge    = (rem_shift >= {1'b0, dur_q});

  // quotient is below the span magnitude, so 32 bits hold it
  assign quot = prod_q[INC_W-1:0];
  assign part = span_neg_q ? (INC_W'(0) - quot) : quot;

  always_comb begin
    if (!glide_q) begin
      inc_new = start_inc_q;
    end else if (need_div_q) begin
      inc_new = start_inc_q + part;
    end else begin
      inc_new = end_inc_q;
    end
  end

  assign phase_adv = phase_q + cur_inc_q;
  assign amp_ext   = {1'b0, amp_q};
  assign level     = phase_adv[INC_W-1] ? amp_ext : (SAMPLE_W'(0) - amp_ext);

  assign status_o.op       = op_q;
  assign status_o.need_div = need_div_q;

  assign sample_o       = sample_q;
  assign sample_valid_o = sample_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_inc_q <= '0;
      end_inc_q   <= '0;
      dur_q       <= '0;
      glide_q     <= 1'b0;
      amp_q       <= AMP_RESET;
      phase_q     <= '0;
      cur_inc_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_START_INC: start_inc_q <= cfg_data_i[INC_W-1:0];
          CFG_END_INC:   end_inc_q   <= cfg_data_i[INC_W-1:0];
          CFG_DURATION:  dur_q       <= cfg_data_i[MS_W-1:0];
          CFG_GLIDE_EN:  glide_q     <= cfg_data_i[0];
          CFG_AMPLITUDE: amp_q       <= cfg_data_i[AMP_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.inc_update) begin
        cur_inc_q <= inc_new;
      end
      if (cmd_i.commit) begin
        case (op_q)
          OP_SAMPLE:  phase_q <= phase_adv;
          OP_REWIND:  phase_q <= phase_q - prod_q[INC_W-1:0];
          OP_RESTART: phase_q <= '0;
          default: ;
        endcase
      end
    end
  end

  // operands and payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q        <= op_e'(opcode_i);
      elapsed_q   <= elapsed_ms_i;
      count_sat_q <= count_sat;
      need_div_q  <= (op_e'(opcode_i) == OP_SAMPLE) && glide_q && (elapsed_ms_i < dur_q);
      span_neg_q  <= span_neg;
      span_mag_q  <= span_neg ? (start_inc_q - end_inc_q) : (end_inc_q - start_inc_q);
    end
    if (cmd_i.mul) begin
      rem_q <= '0;
      if (op_q == OP_SAMPLE) begin
        prod_q <= glide_full;
      end else begin
        prod_q <= PROD_W'(rew_full[INC_W-1:0]);
      end
    end else if (cmd_i.div_step) begin
      rem_q  <= rem_ge ? MS_W'(rem_shift - {1'b0, dur_q}) : rem_shift[MS_W-1:0];
      prod_q <= {prod_q[PROD_W-2:0], rem_ge};
    end
    if (cmd_i.commit) begin
      sample_valid_q <= (op_q == OP_SAMPLE);
      sample_q       <= (op_q == OP_SAMPLE) ? level : '0;
    end
  end

endmodule

// File: hw/rtl/dds_square_tone_with_glide.sv
// ----------------------------------------------------------------------------
// dds_square_tone_with_glide
// 32-bit phase-accumulator square-wave tone generator with linear pitch glide
// ----------------------------------------------------------------------------
// usage
//   request channel (in_valid_i / in_ready_o): opcode, elapsed ms, rewind count
//   result channel (out_valid_o / out_ready_i): one result per request,
//     sample and sample_valid; non-sample requests return zero, valid low
//   config: plain write port, registers taken on any edge with cfg_we_i high;
//     write only while no request is in flight, not enforced by the block
// sequence, accept to result valid
//   sample with glide in progress: evaluate, divider, increment, commit
//   other samples skip the divider; rewind/restart/no-op: evaluate, commit
// request flow
//   one request in flight; the next transfer is taken the cycle after the
//   result is written
// reset
//   phase and increment clear, config returns to defaults (amplitude 16000)
// stall
//   a finished result waits in the output register; the next request is
//   accepted meanwhile and works up to its commit, where it holds until the
//   register is taken
// ----------------------------------------------------------------------------
module dds_square_tone_with_glide (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration
  input  logic                            cfg_we_i,
  input  logic [dst_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [dst_pkg::CFG_W-1:0]       cfg_data_i,
  // request
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [dst_pkg::OP_W-1:0]        opcode_i,
  input  logic [dst_pkg::MS_W-1:0]        elapsed_ms_i,
  input  logic [dst_pkg::CNT_W-1:0]       rewind_count_i,
  // result
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [dst_pkg::SAMPLE_W-1:0] sample_o,
  output logic                            sample_valid_o
);
  import dst_pkg::*;

  // command and status between sequencer and datapath
  dst_cmd_t    cmd;
  dst_status_t status;

  dst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // datapath: glide product, divider, phase update, output payload
  dst_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .opcode_i       (opcode_i),
    .elapsed_ms_i   (elapsed_ms_i),
    .rewind_count_i (rewind_count_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .sample_o       (sample_o),
    .sample_valid_o (sample_valid_o)
  );

endmodule

// File: hw/rtl/dst_chk.sv
// ----------------------------------------------------------------------------
// dst_chk
// port-level checks for the tone generator, bound to the top level
// ----------------------------------------------------------------------------
module dst_chk (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic [dst_pkg::SAMPLE_W-1:0]    sample_o,
  input logic                            sample_valid_o
);
  import dst_pkg::*;

  // held result stays until transferred
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a non-sample result carries zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !sample_valid_o |-> sample_o == '0)
    else $error("non-sample result carries a level");

  // one request at a time: busy right after a transfer in
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second request taken while busy");

  // with no result held, accepting a request does not raise out_valid_o at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !out_valid_o |=> !out_valid_o)
    else $error("result appeared too early");

endmodule

bind dds_square_tone_with_glide dst_chk u_dst_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .sample_o       (sample_o),
  .sample_valid_o (sample_valid_o)
);
